FILE: rtl/ltc_pkg.sv
`timescale 1ns / 1ps

package ltc_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_INIT_SP    = 3'd0;
	localparam logic [2:0] REG_SP_MIN     = 3'd1;
	localparam logic [2:0] REG_SP_MAX     = 3'd2;
	localparam logic [2:0] REG_SP_STEP    = 3'd3;
	localparam logic [2:0] REG_BAND       = 3'd4;
	localparam logic [2:0] REG_BLINK      = 3'd5;
	localparam logic [2:0] REG_IDLE_CLEAR = 3'd6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Register reset values
	localparam logic [6:0] RST_SP_MIN     = 7'd35;
	localparam logic [6:0] RST_SP_MAX     = 7'd75;
	localparam logic [3:0] RST_SP_STEP    = 4'd5;
	localparam logic [3:0] RST_BAND       = 4'd5;
	localparam logic [7:0] RST_BLINK      = 8'd20;
	localparam logic [7:0] RST_IDLE_CLEAR = 8'd100;

	// Setpoint load window and fallback
	localparam logic [6:0] SP_LOAD_LOW  = 7'd35;
	localparam logic [6:0] SP_LOAD_HIGH = 7'd75;
	localparam logic [6:0] SP_DEFAULT   = 7'd60;

	// Password keys, ASCII '1' and '2'
	localparam logic [7:0] KEY_FIRST  = 8'h31;
	localparam logic [7:0] KEY_SECOND = 8'h32;

	// floor(s*150/307) == (s * 150 * ceil(2^27/307)) >> 27, exact for s*150 < 2^18
	localparam int          TEMP_SHIFT  = 27;
	localparam int          TEMP_MULT_W = 26;
	localparam logic [25:0] TEMP_MULT   = 26'd65578800;

	typedef struct packed {
		logic [6:0] setpoint_min;
		logic [6:0] setpoint_max;
		logic [3:0] setpoint_step;
		logic [3:0] band;
		logic [7:0] blink_ticks;
		logic [7:0] idle_clear_ticks;
	} cfg_t;

	typedef struct packed {
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       power_on;
		logic       up_press;
		logic       down_press;
		logic       button_held;
		logic [8:0] temperature;
	} item_t;

	typedef struct packed {
		logic       heater_on;
		logic       cooler_on;
		logic       led_on;
		logic       display_clear;
		logic       display_refresh;
		logic [6:0] setpoint_out;
		logic       store_write;
		logic       unlocked;
		logic       unlock_notice;
		logic [8:0] temperature;
	} result_t;

	function automatic logic [6:0] load_setpoint(input logic [6:0] value);
		if (value < SP_LOAD_LOW || value > SP_LOAD_HIGH)
			return SP_DEFAULT;
		return value;
	endfunction

endpackage

FILE: rtl/ltc_temp_conv.sv
`timescale 1ns / 1ps

// Sample to degrees: one constant multiply, result taken from the top bits.
module ltc_temp_conv (
	input  logic [9:0] adc_sample,
	output logic [8:0] temperature
);

	localparam int PROD_W = 10 + ltc_pkg::TEMP_MULT_W;

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(adc_sample) * PROD_W'(ltc_pkg::TEMP_MULT);
	assign temperature = prod[ltc_pkg::TEMP_SHIFT +: 9];

endmodule

FILE: rtl/ltc_ctrl.sv
`timescale 1ns / 1ps

// Lock, setpoint, heater/cooler and tick state; one item per advance.
module ltc_ctrl #(
	parameter int TICK_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  ltc_pkg::item_t     item,
	input  ltc_pkg::cfg_t      cfg,
	input  logic               sp_load,
	input  logic [6:0]         sp_load_val,
	output ltc_pkg::result_t   res
);

	localparam int CW = (TICK_BITS > 8) ? TICK_BITS : 8;

	logic                 first_q, second_q, notice_done_q, mode_q;
	logic                 heater_q, cooler_q, led_q, blink_en_q;
	logic [6:0]           sp_q;
	logic [TICK_BITS-1:0] tick_q;

	logic                 first_n, second_n, notice_done_n, mode_n;
	logic                 heater_n, cooler_n, led_n, blink_en_n;
	logic [6:0]           sp_n;
	logic [TICK_BITS-1:0] tick_n;

	logic       unl, notice, clr, refresh, store;
	logic [7:0] sum;
	logic [6:0] diff;
	logic [6:0] lo;
	logic [7:0] hi;
	logic       lo_neg, eq_lo, eq_hi, in_band;

	always_comb begin
		first_n       = first_q  | (item.rx_valid && item.rx_byte == ltc_pkg::KEY_FIRST);
		second_n      = second_q | (item.rx_valid && item.rx_byte == ltc_pkg::KEY_SECOND);
		unl           = first_n && second_n;
		notice        = unl && !notice_done_q;
		notice_done_n = notice_done_q | unl;
		mode_n        = mode_q;
		heater_n      = heater_q;
		cooler_n      = cooler_q;
		led_n         = led_q;
		blink_en_n    = blink_en_q;
		sp_n          = sp_q;
		tick_n        = tick_q;
		clr           = 1'b0;
		refresh       = 1'b0;
		store         = 1'b0;

		// step arithmetic, clamped on one side only
		sum  = {1'b0, sp_q} + {4'b0, cfg.setpoint_step};
		diff = sp_q - {3'b0, cfg.setpoint_step};

		if (unl && item.power_on) begin
			if (item.up_press || item.down_press) begin
				refresh = 1'b1;
				if (!mode_q) begin
					mode_n = 1'b1;
				end else begin
					store = 1'b1;
					if (item.up_press) begin
						sp_n = (sum > {1'b0, cfg.setpoint_max}) ? cfg.setpoint_max : sum[6:0];
					end else begin
						sp_n = (sp_q < {3'b0, cfg.setpoint_step} || diff < cfg.setpoint_min) ?
							cfg.setpoint_min : diff;
					end
				end
			end
		end

		// band edges around the updated setpoint; a negative low edge never matches
		lo_neg  = sp_n < {3'b0, cfg.band};
		lo      = sp_n - {3'b0, cfg.band};
		hi      = {1'b0, sp_n} + {4'b0, cfg.band};
		eq_lo   = !lo_neg && item.temperature == {2'b0, lo};
		eq_hi   = item.temperature == {1'b0, hi};
		in_band = (lo_neg || item.temperature >= {2'b0, lo}) &&
			item.temperature < {1'b0, hi};

		if (unl && item.power_on) begin
			if (eq_lo) begin
				heater_n   = 1'b1;
				cooler_n   = 1'b0;
				blink_en_n = 1'b1;
			end
			// cooler edge comes second, so it wins at zero band
			if (eq_hi) begin
				cooler_n   = 1'b1;
				heater_n   = 1'b0;
				led_n      = 1'b1;
				blink_en_n = 1'b0;
			end
			tick_n = tick_q + 1'b1;
			if (CW'(tick_n) == CW'(cfg.blink_ticks) && in_band && blink_en_n) begin
				led_n  = !led_n;
				tick_n = '0;
			end
			if (CW'(tick_n) == CW'(cfg.idle_clear_ticks) && !item.button_held) begin
				clr    = 1'b1;
				tick_n = '0;
			end
		end else if (unl) begin
			clr = 1'b1;
		end

		res.heater_on       = heater_n;
		res.cooler_on       = cooler_n;
		res.led_on          = led_n;
		res.display_clear   = clr;
		res.display_refresh = refresh;
		res.setpoint_out    = sp_n;
		res.store_write     = store;
		res.unlocked        = unl;
		res.unlock_notice   = notice;
		res.temperature     = item.temperature;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q       <= 1'b0;
			second_q      <= 1'b0;
			notice_done_q <= 1'b0;
			mode_q        <= 1'b0;
			heater_q      <= 1'b0;
			cooler_q      <= 1'b0;
			led_q         <= 1'b0;
			blink_en_q    <= 1'b0;
			sp_q          <= ltc_pkg::SP_DEFAULT;
			tick_q        <= '0;
		end else if (sp_load) begin
			sp_q <= ltc_pkg::load_setpoint(sp_load_val);
		end else if (advance) begin
			first_q       <= first_n;
			second_q      <= second_n;
			notice_done_q <= notice_done_n;
			mode_q        <= mode_n;
			heater_q      <= heater_n;
			cooler_q      <= cooler_n;
			led_q         <= led_n;
			blink_en_q    <= blink_en_n;
			sp_q          <= sp_n;
			tick_q        <= tick_n;
		end
	end

endmodule

FILE: rtl/locked_thermostat_controller.sv
`timescale 1ns / 1ps
// An accepted item waits in the input register, its result in the result register.
// Throughput: one item per cycle while results are taken; the two registers form
// a two-stage pipeline. While a result waits, the input side takes one more item
// into an empty input register and then stalls until the result is taken.
// Reset (arst_n low, asynchronous): lock cleared, setpoint 60, levels and counter
// zero, configuration back to its defaults, both pipeline stages empty.
module locked_thermostat_controller #(
	parameter int TICK_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,

	// configuration write port
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,

	// input item channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       rx_valid,
	input  logic [7:0] rx_byte,
	input  logic       power_on,
	input  logic       up_press,
	input  logic       down_press,
	input  logic       button_held,
	input  logic [9:0] adc_sample,

	// result item channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       heater_on,
	output logic       cooler_on,
	output logic       led_on,
	output logic       display_clear,
	output logic       display_refresh,
	output logic [6:0] setpoint_out,
	output logic       store_write,
	output logic       unlocked,
	output logic       unlock_notice,
	output logic [8:0] temperature
);

	// ------------------------------------------------------------------
	// Configuration registers. initial_setpoint has no storage of its own:
	// a write to it reloads the live setpoint right away.
	// ------------------------------------------------------------------
	ltc_pkg::cfg_t cfg_q;
	logic          sp_load;

	assign sp_load = cfg_we && cfg_index == ltc_pkg::REG_INIT_SP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint_min     <= ltc_pkg::RST_SP_MIN;
			cfg_q.setpoint_max     <= ltc_pkg::RST_SP_MAX;
			cfg_q.setpoint_step    <= ltc_pkg::RST_SP_STEP;
			cfg_q.band             <= ltc_pkg::RST_BAND;
			cfg_q.blink_ticks      <= ltc_pkg::RST_BLINK;
			cfg_q.idle_clear_ticks <= ltc_pkg::RST_IDLE_CLEAR;
		end else if (cfg_we) begin
			case (cfg_index)
				ltc_pkg::REG_SP_MIN:     cfg_q.setpoint_min     <= cfg_data[6:0];
				ltc_pkg::REG_SP_MAX:     cfg_q.setpoint_max     <= cfg_data[6:0];
				ltc_pkg::REG_SP_STEP:    cfg_q.setpoint_step    <= cfg_data[3:0];
				ltc_pkg::REG_BAND:       cfg_q.band             <= cfg_data[3:0];
				ltc_pkg::REG_BLINK:      cfg_q.blink_ticks      <= cfg_data;
				ltc_pkg::REG_IDLE_CLEAR: cfg_q.idle_clear_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register. The ADC conversion (one constant multiply)
	// is done on the way in, so the stage holds degrees, not raw counts.
	// ------------------------------------------------------------------
	ltc_pkg::item_t item_s1;
	logic           valid_s1;
	logic [8:0]     temp_in;
	logic           advance;
	logic           out_valid_q;

	ltc_temp_conv u_conv (
		.adc_sample  (adc_sample),
		.temperature (temp_in)
	);

	// stage 1 moves on whenever the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.rx_valid    <= rx_valid;
			item_s1.rx_byte     <= rx_byte;
			item_s1.power_on    <= power_on;
			item_s1.up_press    <= up_press;
			item_s1.down_press  <= down_press;
			item_s1.button_held <= button_held;
			item_s1.temperature <= temp_in;
		end
	end

	// ------------------------------------------------------------------
	// Control state; its next value for this item is the result.
	// ------------------------------------------------------------------
	ltc_pkg::result_t res_next;
	ltc_pkg::result_t res_q;

	ltc_ctrl #(
		.TICK_BITS (TICK_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item_s1),
		.cfg         (cfg_q),
		.sp_load     (sp_load),
		.sp_load_val (cfg_data[6:0]),
		.res         (res_next)
	);

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign heater_on       = res_q.heater_on;
	assign cooler_on       = res_q.cooler_on;
	assign led_on          = res_q.led_on;
	assign display_clear   = res_q.display_clear;
	assign display_refresh = res_q.display_refresh;
	assign setpoint_out    = res_q.setpoint_out;
	assign store_write     = res_q.store_write;
	assign unlocked        = res_q.unlocked;
	assign unlock_notice   = res_q.unlock_notice;
	assign temperature     = res_q.temperature;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// the input side only stalls behind a full, blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	// heater and cooler levels are mutually exclusive
	a_drive_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(heater_on && cooler_on))
		else $error("heater and cooler driven together");

	// a save only happens on a setpoint step, which always refreshes the display
	a_store_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && store_write) |-> (display_refresh && unlocked))
		else $error("store without refresh or while locked");

	// a notice is only given while unlocked
	a_notice_unl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && unlock_notice) |-> unlocked)
		else $error("unlock notice while locked");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int RUN_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;

	// How the driver picks the sensor sample of a tick. RAW keeps the value
	// in the item; LOW and HIGH aim at the switching points of the current setpoint, MID inside its band.
	typedef enum logic [1:0] {AIM_RAW, AIM_LOW, AIM_HIGH, AIM_MID} aim_t;

	typedef struct {
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       power_on;
		logic       up_press;
		logic       down_press;
		logic       button_held;
		logic [9:0] adc_sample;
		aim_t       aim;
		int         aim_off;
	} tick_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       rx_valid = 1'b0;
	logic [7:0] rx_byte = '0;
	logic       power_on = 1'b0;
	logic       up_press = 1'b0;
	logic       down_press = 1'b0;
	logic       button_held = 1'b0;
	logic [9:0] adc_sample = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       heater_on, cooler_on, led_on, display_clear, display_refresh;
	logic [6:0] setpoint_out;
	logic       store_write, unlocked, unlock_notice;
	logic [8:0] temperature;

	locked_thermostat_controller dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.rx_valid(rx_valid), .rx_byte(rx_byte), .power_on(power_on),
		.up_press(up_press), .down_press(down_press), .button_held(button_held),
		.adc_sample(adc_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.heater_on(heater_on), .cooler_on(cooler_on), .led_on(led_on),
		.display_clear(display_clear), .display_refresh(display_refresh),
		.setpoint_out(setpoint_out), .store_write(store_write),
		.unlocked(unlocked), .unlock_notice(unlock_notice),
		.temperature(temperature)
	);

	// Ticks waiting to be offered, and the status each accepted tick must produce
	tick_t            tick_q[$];
	ltc_pkg::result_t status_q[$];
	tick_t            offered;

	int idle_pct = 38;
	int errors = 0;
	int cycles = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_settings = 1;
	int n_steps = 0;
	int n_heat = 0;
	int n_cool = 0;
	int n_blinks = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// Thermostat state as the block should hold it
	logic       key1_seen, key2_seen, notice_sent;
	logic [6:0] sp_now;
	logic       in_setting, heat_lvl, cool_lvl, led_lvl, blink_armed;
	logic [7:0] tick_cnt;
	logic [6:0] r_init, r_min, r_max;
	logic [3:0] r_step, r_band;
	logic [7:0] r_blink, r_idle;

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop if the handshakes ever lock up
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Setpoint taken from the initial register: only inside the load window,
	// otherwise the fallback value.
	function automatic logic [6:0] start_setpoint(input logic [6:0] value);
		if (value < ltc_pkg::SP_LOAD_LOW || value > ltc_pkg::SP_LOAD_HIGH)
			return ltc_pkg::SP_DEFAULT;
		return value;
	endfunction

	// Advance the thermostat by one tick and return the status it shows
	function automatic ltc_pkg::result_t next_status(input tick_t t);
		ltc_pkg::result_t r;
		int      temp, lo, hi, nsp;
		logic    clr, refresh, store, notice;
		temp = (int'(t.adc_sample) * 150) / 307;
		clr = 1'b0;
		refresh = 1'b0;
		store = 1'b0;
		notice = 1'b0;
		// keys latch whether or not power is on; valid strobe gates them
		if (t.rx_valid) begin
			if (t.rx_byte == ltc_pkg::KEY_FIRST) key1_seen = 1'b1;
			if (t.rx_byte == ltc_pkg::KEY_SECOND) key2_seen = 1'b1;
		end
		if (key1_seen && key2_seen) begin
			if (!notice_sent) begin
				notice = 1'b1;
				notice_sent = 1'b1;
			end
			if (t.power_on) begin
				if (t.up_press || t.down_press) begin
					refresh = 1'b1;
					// first press after unlock only enters setting mode
					if (!in_setting) begin
						in_setting = 1'b1;
					end else begin
						store = 1'b1;
						n_steps++;
						// up wins; each direction clamps on its own bound only
						if (t.up_press) begin
							nsp = int'(sp_now) + int'(r_step);
							if (nsp > int'(r_max)) nsp = int'(r_max);
						end else begin
							nsp = int'(sp_now) - int'(r_step);
							if (nsp < int'(r_min)) nsp = int'(r_min);
						end
						sp_now = nsp[6:0];
					end
				end
				lo = int'(sp_now) - int'(r_band);
				hi = int'(sp_now) + int'(r_band);
				// exact equality switching; cooler is checked last so it wins at band 0
				if (temp == lo) begin
					heat_lvl = 1'b1;
					cool_lvl = 1'b0;
					blink_armed = 1'b1;
					n_heat++;
				end
				if (temp == hi) begin
					cool_lvl = 1'b1;
					heat_lvl = 1'b0;
					led_lvl = 1'b1;
					blink_armed = 1'b0;
					n_cool++;
				end
				tick_cnt = tick_cnt + 8'd1;
				if (tick_cnt == r_blink && temp >= lo && temp < hi && blink_armed) begin
					led_lvl = !led_lvl;
					tick_cnt = '0;
					n_blinks++;
				end
				// idle check sees the counter after a possible blink reset
				if (tick_cnt == r_idle && !t.button_held) begin
					clr = 1'b1;
					tick_cnt = '0;
				end
			end else begin
				clr = 1'b1;
			end
		end
		r.heater_on = heat_lvl;
		r.cooler_on = cool_lvl;
		r.led_on = led_lvl;
		r.display_clear = clr;
		r.display_refresh = refresh;
		r.setpoint_out = sp_now;
		r.store_write = store;
		r.unlocked = key1_seen && key2_seen;
		r.unlock_notice = notice;
		r.temperature = temp[8:0];
		return r;
	endfunction

	// Pick a sample whose temperature lands on (or next to) a switching point, or inside
	// the band, of the setpoint as it stands when the tick is offered.
	function automatic logic [9:0] aim_sample(input tick_t t);
		int lo, hi, goal, base, s_lo, s_hi;
		lo = int'(sp_now) - int'(r_band);
		hi = int'(sp_now) + int'(r_band);
		case (t.aim)
			AIM_LOW: goal = lo + t.aim_off;
			AIM_HIGH: goal = hi + t.aim_off;
			AIM_MID: begin
				base = (lo < 0) ? 0 : lo;
				goal = (hi - 1 > base) ? base + int'($urandom_range(hi - 1 - base)) : base;
			end
			default: return t.adc_sample;
		endcase
		if (goal < 0) goal = 0;
		if (goal > 499) goal = 499;
		// every sample in [s_lo, s_hi] converts to goal
		s_lo = (goal * 307 + 149) / 150;
		s_hi = ((goal + 1) * 307 - 1) / 150;
		if (s_hi > 1023) s_hi = 1023;
		return 10'($urandom_range(s_hi, s_lo));
	endfunction

	function automatic tick_t mk(input logic rxv, input logic [7:0] rxb, input logic pwr,
			input logic up, input logic dn, input logic held, input logic [9:0] adc,
			input aim_t aim);
		tick_t t;
		t.rx_valid = rxv;
		t.rx_byte = rxb;
		t.power_on = pwr;
		t.up_press = up;
		t.down_press = dn;
		t.button_held = held;
		t.adc_sample = adc;
		t.aim = aim;
		t.aim_off = 0;
		return t;
	endfunction

	// Mostly powered ticks aimed at the switching points or inside the band, with
	// presses and stray key bytes; a quarter keep a fully random sample as noise.
	function automatic tick_t rand_tick();
		tick_t t;
		int    pick;
		t.rx_valid = ($urandom_range(99) < 10);
		pick = $urandom_range(3);
		t.rx_byte = (pick == 0) ? ltc_pkg::KEY_FIRST :
			(pick == 1) ? ltc_pkg::KEY_SECOND : 8'($urandom);
		t.power_on = ($urandom_range(99) < 92);
		pick = $urandom_range(99);
		t.up_press = (pick < 12) || (pick >= 24 && pick < 27);
		t.down_press = (pick >= 12 && pick < 27);
		t.button_held = ($urandom_range(99) < 25);
		t.adc_sample = 10'($urandom);
		pick = $urandom_range(99);
		t.aim = (pick < 25) ? AIM_RAW : (pick < 50) ? AIM_LOW : (pick < 65) ? AIM_HIGH : AIM_MID;
		t.aim_off = ($urandom_range(9) < 6) ? 0 : int'($urandom_range(2)) - 1;
		return t;
	endfunction

	task automatic model_reset();
		r_init = ltc_pkg::SP_DEFAULT;
		r_min = ltc_pkg::RST_SP_MIN;
		r_max = ltc_pkg::RST_SP_MAX;
		r_step = ltc_pkg::RST_SP_STEP;
		r_band = ltc_pkg::RST_BAND;
		r_blink = ltc_pkg::RST_BLINK;
		r_idle = ltc_pkg::RST_IDLE_CLEAR;
		key1_seen = 1'b0;
		key2_seen = 1'b0;
		notice_sent = 1'b0;
		in_setting = 1'b0;
		heat_lvl = 1'b0;
		cool_lvl = 1'b0;
		led_lvl = 1'b0;
		blink_armed = 1'b0;
		tick_cnt = '0;
		sp_now = start_setpoint(r_init);
	endtask

	// Register write; the block must be idle, so the model can follow at once
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			ltc_pkg::REG_INIT_SP: begin
				r_init = data[6:0];
				sp_now = start_setpoint(r_init);
			end
			ltc_pkg::REG_SP_MIN: r_min = data[6:0];
			ltc_pkg::REG_SP_MAX: r_max = data[6:0];
			ltc_pkg::REG_SP_STEP: r_step = data[3:0];
			ltc_pkg::REG_BAND: r_band = data[3:0];
			ltc_pkg::REG_BLINK: r_blink = data;
			ltc_pkg::REG_IDLE_CLEAR: r_idle = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sender pause: nothing queued, nothing on the input, every status back
	task automatic wait_drain();
		while (tick_q.size() != 0 || status_q.size() != 0 || in_valid)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic run_phase(input int count);
		@(negedge clk);
		for (int i = 0; i < count / 2; i++)
			tick_q.push_back(rand_tick());
		wait_drain();
		@(negedge clk);
		for (int i = count / 2; i < count; i++)
			tick_q.push_back(rand_tick());
		wait_drain();
	endtask

	task automatic run_setting(input logic [7:0] init_sp, input logic [7:0] lo_sp,
			input logic [7:0] hi_sp, input logic [7:0] step, input logic [7:0] band,
			input logic [7:0] blink, input logic [7:0] idle_clr, input int count);
		write_reg(ltc_pkg::REG_INIT_SP, init_sp);
		write_reg(ltc_pkg::REG_SP_MIN, lo_sp);
		write_reg(ltc_pkg::REG_SP_MAX, hi_sp);
		write_reg(ltc_pkg::REG_SP_STEP, step);
		write_reg(ltc_pkg::REG_BAND, band);
		write_reg(ltc_pkg::REG_BLINK, blink);
		write_reg(ltc_pkg::REG_IDLE_CLEAR, idle_clr);
		n_settings++;
		run_phase(count);
	endtask

	// Driver: predicts each tick as it is taken, then may offer the next one
	// whenever the input slot is free. Valid only drops once the offered tick is taken.
	always @(posedge clk or negedge arst_n) begin : drive
		tick_t nxt;
		logic  send;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_valid <= 1'b0;
			rx_byte <= '0;
			power_on <= 1'b0;
			up_press <= 1'b0;
			down_press <= 1'b0;
			button_held <= 1'b0;
			adc_sample <= '0;
		end else begin
			if (in_valid && in_ready) begin
				status_q.push_back(next_status(offered));
				n_sent++;
			end
			if (!in_valid || in_ready) begin
				send = (tick_q.size() > 0) && ($urandom_range(99) >= idle_pct);
				if (send) begin
					nxt = tick_q.pop_front();
					// model state is current here: every earlier tick is taken
					nxt.adc_sample = aim_sample(nxt);
					offered = nxt;
					in_valid <= 1'b1;
					rx_valid <= nxt.rx_valid;
					rx_byte <= nxt.rx_byte;
					power_on <= nxt.power_on;
					up_press <= nxt.up_press;
					down_press <= nxt.down_press;
					button_held <= nxt.button_held;
					adc_sample <= nxt.adc_sample;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Monitor: compares each status taken with the oldest prediction. Once,
	// with plenty still queued, it refuses results long enough to back the
	// pipeline up into the input.
	always @(posedge clk or negedge arst_n) begin : watch
		ltc_pkg::result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				n_checked++;
				if (status_q.size() == 0) begin
					errors++;
					$display("%0t: status item with nothing expected", $time);
				end else begin
					want = status_q.pop_front();
					check_field("heater_on", want.heater_on, heater_on);
					check_field("cooler_on", want.cooler_on, cooler_on);
					check_field("led_on", want.led_on, led_on);
					check_field("display_clear", want.display_clear, display_clear);
					check_field("display_refresh", want.display_refresh, display_refresh);
					check_field("setpoint_out", want.setpoint_out, setpoint_out);
					check_field("store_write", want.store_write, store_write);
					check_field("unlocked", want.unlocked, unlocked);
					check_field("unlock_notice", want.unlock_notice, unlock_notice);
					check_field("temperature", want.temperature, temperature);
				end
			end
			if (!hold_done && n_checked >= 250 && tick_q.size() > 20) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	initial begin
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks at the reset configuration
		@(negedge clk);
		// locked: presses and samples change nothing
		tick_q.push_back(mk(1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 10'd1023, AIM_RAW));
		// first key byte without its valid strobe is ignored
		tick_q.push_back(mk(1'b0, ltc_pkg::KEY_FIRST, 1'b1, 1'b0, 1'b1, 1'b0, 10'd0, AIM_RAW));
		tick_q.push_back(mk(1'b1, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 10'h2AA, AIM_RAW));
		// second key first, still locked
		tick_q.push_back(mk(1'b1, ltc_pkg::KEY_SECOND, 1'b0, 1'b0, 1'b0, 1'b0, 10'h155,
			AIM_RAW));
		tick_q.push_back(mk(1'b1, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 10'd300, AIM_RAW));
		// unlock with power off: notice and display clear together
		tick_q.push_back(mk(1'b1, ltc_pkg::KEY_FIRST, 1'b0, 1'b0, 1'b0, 1'b0, 10'd200, AIM_RAW));
		tick_q.push_back(mk(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 10'd200, AIM_RAW));
		// powered, repeated key, heater switch point
		tick_q.push_back(mk(1'b1, ltc_pkg::KEY_FIRST, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0, AIM_LOW));
		// first press only enters setting mode
		tick_q.push_back(mk(1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 10'd1023, AIM_RAW));
		// steps up into the ceiling clamp
		repeat (4) tick_q.push_back(mk(1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0, AIM_MID));
		// both buttons: up wins
		tick_q.push_back(mk(1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 10'd0, AIM_MID));
		repeat (2) tick_q.push_back(mk(1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 10'd0, AIM_RAW));
		tick_q.push_back(mk(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 10'd0, AIM_LOW));
		repeat (3) tick_q.push_back(mk(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0, AIM_MID));
		tick_q.push_back(mk(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0, AIM_HIGH));
		tick_q.push_back(mk(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 10'd1023, AIM_RAW));
		tick_q.push_back(mk(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 10'd1023, AIM_RAW));
		wait_drain();
		run_phase(100);

		// band 0 (both switch points coincide), largest step, fastest blink
		run_setting(8'd35, 8'd0, 8'd127, 8'd15, 8'd0, 8'd1, 8'd255, 130);
		// floor above ceiling, widest band, shortest idle clear
		run_setting(8'd75, 8'd127, 8'd0, 8'd1, 8'd15, 8'd255, 8'd1, 130);
		// initial setpoint just under the load window; no idling on either side
		@(posedge clk);
		idle_pct <= 0;
		run_setting(8'd34, 8'd40, 8'd70, 8'd7, 8'd3, 8'd5, 8'd50, 130);
		@(posedge clk);
		idle_pct <= 38;
		// initial setpoint above the window
		run_setting(8'd127, 8'd20, 8'd100, 8'd3, 8'd2, 8'd3, 8'd7, 130);
		run_setting(8'd0, 8'd35, 8'd75, 8'd5, 8'd5, 8'd20, 8'd100, 130);
		repeat (3) begin
			run_setting(8'($urandom_range(127)), 8'($urandom_range(127)),
				8'($urandom_range(127)), 8'($urandom_range(15, 1)),
				8'($urandom_range(15)),
				($urandom_range(1) != 0) ? 8'($urandom_range(10, 1)) : 8'($urandom_range(255, 1)),
				8'($urandom_range(255, 1)), 120);
		end

		wait_drain();
		repeat (10) @(posedge clk);
		$display("run: %0d ticks over %0d register settings, %0d status items compared",
			n_sent, n_settings, n_checked);
		$display("run: %0d setpoint steps, %0d heater and %0d cooler switch points, %0d led toggles",
			n_steps, n_heat, n_cool, n_blinks);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
